// ===== rtl/csvt_pkg.sv =====
// CSV tokenizer package: character codes, result kinds and the word types
// shared by the decode stage, the result queue and the top level.
// No dependencies.
`timescale 1ns / 1ps

package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    // Zero, one or two result words produced by one accepted byte.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== rtl/csvt_decode.sv =====
// CSV tokenizer decode stage: quote/CR state registers and the combinational
// byte classification that yields up to two result words per input byte.
// Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_end_of_input,
    output csvt_pkg::t_push o_push
);
    import csvt_pkg::*;

    typedef enum logic [1:0] {
        Q_PLAIN   = 2'd0,
        Q_QUOTED  = 2'd1,
        Q_PENDING = 2'd2
    } t_qmode;

    t_qmode     r_qmode, n_qmode;
    logic       r_cr,  n_cr;
    logic       r_fne, n_fne;
    logic       r_rhf, n_rhf;

    logic       swallow;
    logic       plain;
    logic       main_v;
    t_kind      main_kind;
    logic [7:0] main_byte;
    logic       flush;

    always_comb begin
        n_qmode   = r_qmode;
        n_cr      = 1'b0;
        n_fne     = r_fne;
        n_rhf     = r_rhf;
        plain     = 1'b0;
        main_v    = 1'b0;
        main_kind = KIND_BYTE;
        main_byte = i_in_byte;
        swallow   = r_cr && (i_in_byte == CH_LF);

        if (!swallow) begin
            unique case (r_qmode)
                Q_QUOTED: begin
                    if (i_in_byte == CH_QUOTE) begin
                        n_qmode = Q_PENDING;
                    end else begin
                        main_v = 1'b1;
                        n_fne  = 1'b1;
                    end
                end
                Q_PENDING: begin
                    // doubled quote gives a literal quote, anything else closes quoting
                    if (i_in_byte == CH_QUOTE) begin
                        main_v  = 1'b1;
                        n_fne   = 1'b1;
                        n_qmode = Q_QUOTED;
                    end else begin
                        n_qmode = Q_PLAIN;
                        plain   = 1'b1;
                    end
                end
                default: begin
                    n_qmode = Q_PLAIN;
                    plain   = 1'b1;
                end
            endcase

            if (plain) begin
                if (i_in_byte == CH_QUOTE && !r_fne) begin
                    n_qmode = Q_QUOTED;
                end else if (i_in_byte == CH_COMMA) begin
                    main_v    = 1'b1;
                    main_kind = KIND_FIELD;
                    main_byte = 8'd0;
                    n_fne     = 1'b0;
                    n_rhf     = 1'b1;
                end else if (i_in_byte == CH_CR || i_in_byte == CH_LF) begin
                    main_v    = 1'b1;
                    main_kind = KIND_ROW;
                    main_byte = 8'd0;
                    n_fne     = 1'b0;
                    n_rhf     = 1'b0;
                    n_cr      = (i_in_byte == CH_CR);
                end else begin
                    main_v = 1'b1;
                    n_fne  = 1'b1;
                end
            end
        end

        flush = i_end_of_input && (n_fne || n_rhf);

        // end of text: drop all state so the next byte starts fresh
        if (i_end_of_input) begin
            n_qmode = Q_PLAIN;
            n_cr    = 1'b0;
            n_fne   = 1'b0;
            n_rhf   = 1'b0;
        end

        o_push.count        = {1'b0, main_v} + {1'b0, flush};
        o_push.first.kind   = main_v ? main_kind : KIND_ROW;
        o_push.first.data   = main_v ? main_byte : 8'd0;
        o_push.first.last   = !(main_v && flush);
        o_push.second.kind  = KIND_ROW;
        o_push.second.data  = 8'd0;
        o_push.second.last  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmode <= Q_PLAIN;
            r_cr    <= 1'b0;
            r_fne   <= 1'b0;
            r_rhf   <= 1'b0;
        end else if (i_accept) begin
            r_qmode <= n_qmode;
            r_cr    <= n_cr;
            r_fne   <= n_fne;
            r_rhf   <= n_rhf;
        end
    end

`ifndef SYNTH
    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_input) |=>
            (r_qmode == Q_PLAIN && !r_cr && !r_fne && !r_rhf))
        else $error("state not cleared after end of input");

    a_two_needs_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> i_end_of_input)
        else $error("two results without end of input");

    a_cr_only_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cr |-> (r_qmode == Q_PLAIN && !r_fne && !r_rhf))
        else $error("CR pending with open field or quote");
`endif

endmodule

// ===== rtl/csvt_out_queue.sv =====
// CSV tokenizer result queue: small register queue that takes up to two
// result words per cycle with room and hands out one per cycle on ready.
// Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_en,
    input  csvt_pkg::t_push i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output csvt_pkg::t_result o_word
);
    import csvt_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, n_wr;
    logic [QUEUE_AW-1:0]   r_rd, n_rd;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic [1:0]            push_n;
    logic                  pop;
    logic [QUEUE_AW-1:0]   wr_next;

    assign push_n  = i_push_en ? i_push.count : 2'd0;
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + QUEUE_AW'(1);
    assign n_wr    = r_wr + QUEUE_AW'(push_n);
    assign n_rd    = pop ? r_rd + QUEUE_AW'(1) : r_rd;
    assign n_count = r_count + QUEUE_CW'(push_n) - QUEUE_CW'(pop);

    assign o_room  = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= QUEUE_CW'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> o_room)
        else $error("push without room");
`endif

endmodule

// ===== rtl/csv_field_tokenizer_unit.sv =====
// CSV field tokenizer top level: decode stage feeding a four-word result queue.
// Depends on csvt_pkg, csvt_decode and csvt_out_queue.
`timescale 1ns / 1ps

// Streaming CSV tokenizer. Takes one text byte per cycle while ready, returns
// content words (quotes unescaped), field-end and row-end words, each with a
// flag on the last word that byte caused. An accepted byte's words are
// registered in the result queue. Throughput is one byte per cycle while the
// output side takes one word per cycle; the output port moves one word per
// cycle, so a flush row-end word added by the byte marked end of input leaves
// after that byte's own word. Input ready is low while the four-word result
// queue has fewer than two free entries. A swallowed LF after CR yields no word.
module csv_field_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import csvt_pkg::*;

    logic    accept;
    t_push   push;
    t_result word;

    assign accept = i_valid && o_ready;

    csvt_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push)
    );

    csvt_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (accept),
        .i_push    (push),
        .o_room    (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_word    (word)
    );

    assign o_kind        = word.kind;
    assign o_out_byte    = word.data;
    assign o_last_of_run = word.last;

endmodule
